>>> rtl/core/i2cbbw_pkg.sv
// Package for the write-only I2C bit-bang master: request codes, line actions,
// controller/datapath command and status structs, and the phase sequence decoder.
// No dependencies.
package i2cbbw_pkg;

  localparam int unsigned PHASE_W    = 16;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned MSB_IDX    = 7;
  localparam int unsigned BIT_CNT_W  = 4;
  localparam int unsigned STEP_W     = 2;

  // Bit count value that selects the acknowledge slot after the eight data bits.
  localparam logic [BIT_CNT_W-1:0] ACK_BIT = 4'd8;

  localparam logic [CFG_IDX_W-1:0] CFG_BUS_ENABLE   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_PHASE_CYCLES = 1'b1;

  localparam logic [PHASE_W-1:0] PHASE_CYCLES_RST = 16'd250;

  typedef enum logic [1:0] {
    REQ_START = 2'd0,
    REQ_WRITE = 2'd1,
    REQ_STOP  = 2'd2
  } req_t;

  typedef enum logic [2:0] {
    ACT_SCL_HI  = 3'd0,
    ACT_SCL_LO  = 3'd1,
    ACT_SDA_HI  = 3'd2,
    ACT_SDA_LO  = 3'd3,
    ACT_SDA_BIT = 3'd4
  } act_t;

  typedef struct packed {
    act_t act;
    logic last;
  } phase_op_t;

  typedef struct packed {
    logic       load;
    logic [7:0] data;
    logic       apply;
    act_t       act;
    logic       last;
    logic       hold_start;
    logic       hold_tick;
  } dp_cmd_t;

  typedef struct packed {
    logic bus_enable;
    logic hold_done;
    logic last;
  } dp_stat_t;

  // Line action and end marker for one phase of a request.
  function automatic phase_op_t phase_decode(req_t req, logic [STEP_W-1:0] step,
                                             logic [BIT_CNT_W-1:0] bit_idx);
    phase_op_t op;
    op.act  = ACT_SCL_HI;
    op.last = 1'b0;
    case (req)
      REQ_START: begin
        case (step)
          2'd0:    op.act = ACT_SCL_HI;
          2'd1:    op.act = ACT_SDA_HI;
          2'd2:    op.act = ACT_SDA_LO;
          default: begin
            op.act  = ACT_SCL_LO;
            op.last = 1'b1;
          end
        endcase
      end
      REQ_WRITE: begin
        case (step)
          2'd0:    op.act = (bit_idx < ACK_BIT) ? ACT_SDA_BIT : ACT_SDA_HI;
          2'd1:    op.act = ACT_SCL_HI;
          default: begin
            op.act  = ACT_SCL_LO;
            op.last = (bit_idx == ACK_BIT);
          end
        endcase
      end
      REQ_STOP: begin
        case (step)
          2'd0:    op.act = ACT_SDA_LO;
          2'd1:    op.act = ACT_SCL_HI;
          default: begin
            op.act  = ACT_SDA_HI;
            op.last = 1'b1;
          end
        endcase
      end
      default: begin
        op.act  = ACT_SCL_HI;
        op.last = 1'b1;
      end
    endcase
    return op;
  endfunction

endpackage

>>> rtl/core/i2cbbw_req_if.sv
// Request channel: valid/ready handshake with request type and data byte.
// Depends on nothing.
interface i2cbbw_req_if;
  logic       valid;
  logic       ready;
  logic [1:0] req_type;
  logic [7:0] data_byte;

  modport source (output valid, output req_type, output data_byte, input ready);
  modport sink   (input valid, input req_type, input data_byte, output ready);
endinterface

>>> rtl/core/i2cbbw_phase_if.sv
// Result channel: valid/ready handshake with one SCL/SDA phase word.
// Depends on nothing.
interface i2cbbw_phase_if;
  logic valid;
  logic ready;
  logic scl_release;
  logic sda_release;
  logic last_phase;

  modport source (output valid, output scl_release, output sda_release, output last_phase,
                  input ready);
  modport sink   (input valid, input scl_release, input sda_release, input last_phase,
                  output ready);
endinterface

>>> rtl/core/i2c_bitbang_master_writer_core.sv
// Top level of the write-only I2C bit-bang master: controller plus datapath.
// Depends on i2cbbw_pkg, i2cbbw_req_if, i2cbbw_phase_if, i2cbbw_ctrl, i2cbbw_dpath.
//
//   port       dir   handshake     word
//   in_req     sink  valid/ready   req_type[1:0], data_byte[7:0]
//   out_phase  src   valid/ready   scl_release, sda_release, last_phase
//   cfg_*      in    cfg_we        cfg_index[0], cfg_wdata[15:0]
//
// Each phase word is offered until out_phase.ready is high and then held by the hold counter,
// loaded from phase_cycles, before the next word is offered.
// A byte write is 27 phases; start is 4, stop is 3.
// One request is worked on at a time; in_req.ready is high only between requests.
// Dropped requests (bus disabled or unused code) are accepted and produce no word.
// Reset is synchronous: both lines released, bus enabled, phase_cycles = 250.
module i2c_bitbang_master_writer_core
  import i2cbbw_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  i2cbbw_req_if.sink            in_req,
  i2cbbw_phase_if.source        out_phase,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  dp_cmd_t  cmd;
  dp_stat_t stat;
  logic     in_ready;
  logic     out_valid;

  i2cbbw_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_req.valid),
    .in_req_type  (in_req.req_type),
    .in_data_byte (in_req.data_byte),
    .in_ready     (in_ready),
    .out_ready    (out_phase.ready),
    .out_valid    (out_valid),
    .stat         (stat),
    .cmd          (cmd)
  );

  i2cbbw_dpath u_dpath (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_wdata   (cfg_wdata),
    .cmd         (cmd),
    .stat        (stat),
    .scl_release (out_phase.scl_release),
    .sda_release (out_phase.sda_release),
    .last_phase  (out_phase.last_phase)
  );

  assign in_req.ready    = in_ready;
  assign out_phase.valid = out_valid;

  // No word is offered while a new request can be taken.
  a_idle_no_word: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> !out_valid)
    else $error("phase word offered while idle");

  // A taken word is followed by a hold, during which no word is offered and no request is taken.
  a_hold_after_word: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_phase.ready) |=> (!out_valid && !in_ready))
    else $error("no hold after phase word");

  // A request taken while the bus is disabled produces nothing.
  a_disabled_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ready && in_req.valid && !stat.bus_enable) |=> (in_ready && !out_valid))
    else $error("activity while bus disabled");

endmodule

>>> rtl/core/i2cbbw_ctrl.sv
// Sequencing controller: request handshake, phase counters and the idle/emit/hold FSM.
// Depends on i2cbbw_pkg.
module i2cbbw_ctrl
  import i2cbbw_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic [1:0] in_req_type,
  input  logic [7:0] in_data_byte,
  output logic       in_ready,
  input  logic       out_ready,
  output logic       out_valid,
  input  dp_stat_t   stat,
  output dp_cmd_t    cmd
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_EMIT = 3'b010,
    ST_HOLD = 3'b100
  } state_t;

  state_t                 state_r, state_nxt;
  req_t                   req_r, req_nxt;
  logic [STEP_W-1:0]      step_r, step_nxt;
  logic [BIT_CNT_W-1:0]   bit_r, bit_nxt;

  req_t                   dec_req;
  logic [STEP_W-1:0]      dec_step;
  logic [BIT_CNT_W-1:0]   dec_bit;
  phase_op_t              op;
  logic                   go;
  logic                   apply;

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = (state_r == ST_EMIT);

  // Requests with an unused code, or taken while the bus is off, are dropped here.
  assign go = in_ready && in_valid && stat.bus_enable &&
              (in_req_type inside {REQ_START, REQ_WRITE, REQ_STOP});

  assign apply = go || ((state_r == ST_HOLD) && stat.hold_done && !stat.last);

  always_comb begin
    if (state_r == ST_IDLE) begin
      dec_req  = req_t'(in_req_type);
      dec_step = '0;
      dec_bit  = '0;
    end else begin
      dec_req  = req_r;
      dec_step = step_r;
      dec_bit  = bit_r;
    end
  end

  assign op = phase_decode(dec_req, dec_step, dec_bit);

  always_comb begin
    req_nxt  = req_r;
    step_nxt = step_r;
    bit_nxt  = bit_r;
    if (apply) begin
      req_nxt = dec_req;
      if ((dec_req == REQ_WRITE) && (dec_step == 2'd2)) begin
        step_nxt = '0;
        bit_nxt  = dec_bit + 1'b1;
      end else begin
        step_nxt = dec_step + 1'b1;
        bit_nxt  = dec_bit;
      end
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (go) state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_ready) state_nxt = ST_HOLD;
      end
      ST_HOLD: begin
        if (stat.hold_done) state_nxt = stat.last ? ST_IDLE : ST_EMIT;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd.load       = go;
    cmd.data       = in_data_byte;
    cmd.apply      = apply;
    cmd.act        = op.act;
    cmd.last       = op.last;
    cmd.hold_start = (state_r == ST_EMIT) && out_ready;
    cmd.hold_tick  = (state_r == ST_HOLD);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r  <= req_nxt;
    step_r <= step_nxt;
    bit_r  <= bit_nxt;
  end

endmodule

>>> rtl/core/i2cbbw_dpath.sv
// Datapath: configuration registers, SCL/SDA line registers, byte shifter and
// phase hold counter. Depends on i2cbbw_pkg.
module i2cbbw_dpath
  import i2cbbw_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  dp_cmd_t               cmd,
  output dp_stat_t              stat,
  output logic                  scl_release,
  output logic                  sda_release,
  output logic                  last_phase
);

  logic               bus_en_r, bus_en_nxt;
  logic [PHASE_W-1:0] phase_cyc_r, phase_cyc_nxt;
  logic               scl_r, scl_nxt;
  logic               sda_r, sda_nxt;
  logic [7:0]         shift_r, shift_nxt;
  logic               last_r, last_nxt;
  logic [PHASE_W-1:0] cnt_r, cnt_nxt;

  logic [7:0]         shift_src;

  always_comb begin
    bus_en_nxt    = bus_en_r;
    phase_cyc_nxt = phase_cyc_r;
    if (cfg_we) begin
      case (cfg_index)
        CFG_BUS_ENABLE:   bus_en_nxt    = cfg_wdata[0];
        CFG_PHASE_CYCLES: phase_cyc_nxt = cfg_wdata[PHASE_W-1:0];
        default: ;
      endcase
    end
  end

  // A new byte is shifted out in the same cycle it is loaded.
  assign shift_src = cmd.load ? cmd.data : shift_r;

  always_comb begin
    scl_nxt   = scl_r;
    sda_nxt   = sda_r;
    shift_nxt = shift_r;
    last_nxt  = last_r;
    if (cmd.load) shift_nxt = cmd.data;
    if (cmd.apply) begin
      last_nxt = cmd.last;
      case (cmd.act)
        ACT_SCL_HI:  scl_nxt = 1'b1;
        ACT_SCL_LO:  scl_nxt = 1'b0;
        ACT_SDA_HI:  sda_nxt = 1'b1;
        ACT_SDA_LO:  sda_nxt = 1'b0;
        ACT_SDA_BIT: begin
          sda_nxt   = shift_src[MSB_IDX];
          shift_nxt = {shift_src[MSB_IDX-1:0], 1'b0};
        end
        default: ;
      endcase
    end
  end

  // The hold counter finishes at one, so a zero setting still gives a hold.
  always_comb begin
    cnt_nxt = cnt_r;
    if (cmd.hold_start) begin
      cnt_nxt = phase_cyc_r;
    end else if (cmd.hold_tick && (cnt_r != '0)) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bus_en_r    <= 1'b1;
      phase_cyc_r <= PHASE_CYCLES_RST;
      scl_r       <= 1'b1;
      sda_r       <= 1'b1;
      shift_r     <= '0;
      last_r      <= 1'b0;
    end else begin
      bus_en_r    <= bus_en_nxt;
      phase_cyc_r <= phase_cyc_nxt;
      scl_r       <= scl_nxt;
      sda_r       <= sda_nxt;
      shift_r     <= shift_nxt;
      last_r      <= last_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r <= cnt_nxt;
  end

  assign stat.bus_enable = bus_en_r;
  assign stat.hold_done  = (cnt_r[PHASE_W-1:1] == '0);
  assign stat.last       = last_r;

  assign scl_release = scl_r;
  assign sda_release = sda_r;
  assign last_phase  = last_r;

endmodule
